@@ src/stbs_pkg.sv @@
package stbs_pkg;

   typedef enum logic {
      ST_IDLE,
      ST_SEARCH
   } state_type;

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SEARCH = 1'b1;

   localparam int          CSR_ADDR_W       = 3;
   localparam int          CSR_DATA_W       = 32;
   localparam int          LEN_W            = 11;
   localparam int          IDX_W            = 10;
   localparam int          VAL_W            = 32;
   localparam int          STEP_W           = 5;
   localparam logic        REG_TABLE_LENGTH = 1'b0;
   localparam logic [10:0] LEN_RESET        = 11'd1024;
   localparam logic [4:0]  STEP_MAX         = 5'd31;

   function automatic logic [STEP_W-1:0] sat_inc(input logic [STEP_W-1:0] s);
      sat_inc = (s == STEP_MAX) ? STEP_MAX : s + 1'b1;
   endfunction

endpackage

@@ src/stbs_table_mem.sv @@
module stbs_table_mem #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [stbs_pkg::VAL_W-1:0]     wr_data,
   input  logic [AW-1:0]                  rd_addr,
   output logic [stbs_pkg::VAL_W-1:0]     rd_data
);

   logic [stbs_pkg::VAL_W-1:0] mem [DEPTH];
   logic [stbs_pkg::VAL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/stbs_search_ctrl.sv @@
module stbs_search_ctrl #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [stbs_pkg::IDX_W-1:0]          req_entry_index,
   input  logic signed [stbs_pkg::VAL_W-1:0]   req_entry_value,
   input  logic signed [stbs_pkg::VAL_W-1:0]   req_search_key,
   input  logic [stbs_pkg::LEN_W-1:0]          table_length,
   output logic                                wr_en,
   output logic [AW-1:0]                       wr_addr,
   output logic [stbs_pkg::VAL_W-1:0]          wr_data,
   output logic [AW-1:0]                       rd_addr,
   input  logic [stbs_pkg::VAL_W-1:0]          rd_data,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic [stbs_pkg::IDX_W-1:0]          rsp_match_index,
   output logic [stbs_pkg::STEP_W-1:0]         rsp_step_count
);

   localparam int BW = ((AW > stbs_pkg::LEN_W) ? AW : stbs_pkg::LEN_W) + 2;

   stbs_pkg::state_type state_ff, state_in;

   logic signed [BW-1:0]               lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic signed [stbs_pkg::VAL_W-1:0]  key_ff, key_in;
   logic [stbs_pkg::STEP_W-1:0]        steps_ff, steps_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_found_ff, rsp_found_in;
   logic [stbs_pkg::IDX_W-1:0]         rsp_index_ff, rsp_index_in;
   logic [stbs_pkg::STEP_W-1:0]        rsp_steps_ff, rsp_steps_in;

   logic                               accept;
   logic signed [BW-1:0]               len_ext, depth_c, len_c, hi0;
   logic signed [BW-1:0]               lo_up, hi_dn, mid_up, mid_dn;
   logic [stbs_pkg::STEP_W-1:0]        step1, step2;
   logic                               eq, lt;

   assign busy    = (state_ff != stbs_pkg::ST_IDLE);
   assign accept  = start && !busy;

   assign wr_en   = accept && (req_opcode == stbs_pkg::OP_WRITE)
                    && (32'(req_entry_index) < 32'(DEPTH));
   assign wr_addr = AW'(req_entry_index);
   assign wr_data = req_entry_value;

   assign len_ext = BW'(table_length);
   assign depth_c = BW'(DEPTH);
   assign len_c   = (len_ext > depth_c) ? depth_c : len_ext;
   assign hi0     = len_c - BW'(1);

   assign eq      = ($signed(rd_data) == key_ff);
   assign lt      = ($signed(rd_data) < key_ff);
   assign lo_up   = mid_ff + BW'(1);
   assign hi_dn   = mid_ff - BW'(1);
   assign mid_up  = (lo_up + hi_ff) >>> 1;
   assign mid_dn  = (lo_ff + hi_dn) >>> 1;
   assign step1   = stbs_pkg::sat_inc(steps_ff);
   assign step2   = stbs_pkg::sat_inc(step1);

   always_comb begin
      state_in     = state_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      steps_in     = steps_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_index_in = rsp_index_ff;
      rsp_steps_in = rsp_steps_ff;
      unique case (state_ff)
         stbs_pkg::ST_IDLE: begin
            if (accept && (req_opcode == stbs_pkg::OP_SEARCH)) begin
               key_in   = req_search_key;
               steps_in = '0;
               lo_in    = '0;
               hi_in    = hi0;
               mid_in   = hi0 >>> 1;
               if (len_c == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_index_in = '0;
                  rsp_steps_in = '0;
               end else begin
                  state_in = stbs_pkg::ST_SEARCH;
               end
            end
         end
         stbs_pkg::ST_SEARCH: begin
            priority if (eq) begin
               state_in     = stbs_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_index_in = stbs_pkg::IDX_W'(mid_ff);
               rsp_steps_in = step1;
            end else if (lt) begin
               lo_in    = lo_up;
               mid_in   = mid_up;
               steps_in = step2;
               if (lo_up > hi_ff) begin
                  state_in     = stbs_pkg::ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_index_in = '0;
                  rsp_steps_in = step2;
               end
            end else begin
               hi_in    = hi_dn;
               mid_in   = mid_dn;
               steps_in = step2;
               if (lo_ff > hi_dn) begin
                  state_in     = stbs_pkg::ST_IDLE;
                  rsp_valid_in = 1'b1;
                  rsp_found_in = 1'b0;
                  rsp_index_in = '0;
                  rsp_steps_in = step2;
               end
            end
         end
         default: begin
            state_in = stbs_pkg::ST_IDLE;
         end
      endcase
   end

   assign rd_addr = AW'(mid_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stbs_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mid_ff       <= mid_in;
      key_ff       <= key_in;
      steps_ff     <= steps_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
      rsp_steps_ff <= rsp_steps_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_match_index = rsp_index_ff;
   assign rsp_step_count  = rsp_steps_ff;

endmodule

@@ src/sorted_table_binary_search.sv @@
// Write request: stored at the accepting edge, no result.
// Search request: probes the table memory, which has a registered read port, at most
// floor(log2(len))+1 probes with len capped at DEPTH; the result strobe is registered
// from the last probe; busy meanwhile, and no new request is taken until the result.
// Empty table: result strobe in the cycle after accept. Receiver cannot stall.
// Reset: synchronous, clears control and sets table_length to 1024; table contents unknown.
module sorted_table_binary_search #(
   parameter int DEPTH = 1024
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          start,
   output logic                                          busy,
   input  logic                                          req_opcode,
   input  logic [stbs_pkg::IDX_W-1:0]                    req_entry_index,
   input  logic signed [stbs_pkg::VAL_W-1:0]             req_entry_value,
   input  logic signed [stbs_pkg::VAL_W-1:0]             req_search_key,
   output logic                                          rsp_valid,
   output logic                                          rsp_found,
   output logic [stbs_pkg::IDX_W-1:0]                    rsp_match_index,
   output logic [stbs_pkg::STEP_W-1:0]                   rsp_step_count,
   input  logic                                          psel,
   input  logic                                          penable,
   input  logic                                          pwrite,
   input  logic [stbs_pkg::CSR_ADDR_W-1:0]               paddr,
   input  logic [stbs_pkg::CSR_DATA_W-1:0]               pwdata,
   output logic [stbs_pkg::CSR_DATA_W-1:0]               prdata,
   output logic                                          pready
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [stbs_pkg::LEN_W-1:0]  table_length_ff;
   logic                        csr_sel_len;
   logic                        wr_en;
   logic [AW-1:0]               wr_addr, rd_addr;
   logic [stbs_pkg::VAL_W-1:0]  wr_data, rd_data;

   assign pready      = 1'b1;
   assign csr_sel_len = (paddr[stbs_pkg::CSR_ADDR_W-1] == stbs_pkg::REG_TABLE_LENGTH);
   assign prdata      = csr_sel_len ? stbs_pkg::CSR_DATA_W'(table_length_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff <= stbs_pkg::LEN_RESET;
      end else if (psel && penable && pwrite && pready && csr_sel_len) begin
         table_length_ff <= pwdata[stbs_pkg::LEN_W-1:0];
      end
   end

   stbs_search_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .table_length    (table_length_ff),
      .wr_en           (wr_en),
      .wr_addr         (wr_addr),
      .wr_data         (wr_data),
      .rd_addr         (rd_addr),
      .rd_data         (rd_data),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_match_index (rsp_match_index),
      .rsp_step_count  (rsp_step_count)
   );

   stbs_table_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

@@ src/stbs_checker.sv @@
module stbs_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic                                req_opcode,
   input logic                                rsp_valid,
   input logic                                rsp_found,
   input logic [stbs_pkg::IDX_W-1:0]          rsp_match_index,
   input logic [stbs_pkg::STEP_W-1:0]         rsp_step_count
);

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_search_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == stbs_pkg::OP_SEARCH) |=> (busy || rsp_valid))
      else $error("search request neither busy nor answered");

   a_write_no_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == stbs_pkg::OP_WRITE) |=> (!busy && !rsp_valid))
      else $error("write request caused busy or a result");

   a_miss_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_index == '0))
      else $error("miss with nonzero index");

   a_hit_steps_odd: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found && rsp_step_count != stbs_pkg::STEP_MAX)
         |-> rsp_step_count[0])
      else $error("hit with even step count");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_opcode      (req_opcode),
   .rsp_valid       (rsp_valid),
   .rsp_found       (rsp_found),
   .rsp_match_index (rsp_match_index),
   .rsp_step_count  (rsp_step_count)
);

@@ dv/tb_sorted_table_binary_search.sv @@
`timescale 1ns / 100ps

module tb_sorted_table_binary_search;

   localparam int DEPTH           = 1024;
   localparam int DRAIN_CYCLES    = 16;
   localparam int RANDOM_REQUESTS = 380;
   localparam logic [stbs_pkg::CSR_ADDR_W-1:0] LEN_ADDR   =
      {stbs_pkg::REG_TABLE_LENGTH, 2'b00};
   localparam logic [stbs_pkg::CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;

   typedef struct packed {
      logic                        found;
      logic [stbs_pkg::IDX_W-1:0]  index;
      logic [stbs_pkg::STEP_W-1:0] steps;
   } search_result_type;

   typedef enum {
      ROW_CSR,
      ROW_WRITE,
      ROW_SEARCH
   } row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      logic [stbs_pkg::CSR_ADDR_W-1:0] addr;
      logic [31:0]                     value;
      logic [stbs_pkg::IDX_W-1:0]      index;
      bit                              known;
      search_result_type               result;
   } directed_row_type;

   logic                                clock;
   logic                                reset;
   logic                                start;
   logic                                busy;
   logic                                req_opcode;
   logic [stbs_pkg::IDX_W-1:0]          req_entry_index;
   logic signed [stbs_pkg::VAL_W-1:0]   req_entry_value;
   logic signed [stbs_pkg::VAL_W-1:0]   req_search_key;
   logic                                rsp_valid;
   logic                                rsp_found;
   logic [stbs_pkg::IDX_W-1:0]          rsp_match_index;
   logic [stbs_pkg::STEP_W-1:0]         rsp_step_count;
   logic                                psel;
   logic                                penable;
   logic                                pwrite;
   logic [stbs_pkg::CSR_ADDR_W-1:0]     paddr;
   logic [stbs_pkg::CSR_DATA_W-1:0]     pwdata;
   logic [stbs_pkg::CSR_DATA_W-1:0]     prdata;
   logic                                pready;

   logic signed [stbs_pkg::VAL_W-1:0]   table_image [DEPTH];
   bit                                  written [DEPTH];
   logic [stbs_pkg::LEN_W-1:0]          table_length_cfg;
   search_result_type                   pending_results [$];

   int  mismatches      = 0;
   int  requests_issued = 0;
   int  searches_issued = 0;
   int  search_hits     = 0;
   int  length_updates  = 0;
   int  next_gap        = 0;
   bit  start_held      = 1'b0;
   bit  steady          = 1'b0;

   sorted_table_binary_search #(.DEPTH(DEPTH)) dut (.*);

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic search_result_type predict_search(
      input logic signed [stbs_pkg::VAL_W-1:0] key);
      search_result_type res;
      int                lo;
      int                hi;
      int                mid;
      int                n;
      bit                done;
      res  = '0;
      done = 1'b0;
      n    = int'(table_length_cfg);
      if (n > DEPTH) begin
         n = DEPTH;
      end
      lo = 0;
      hi = n - 1;
      while (!done && lo <= hi) begin
         mid = (lo + hi) / 2;
         if (res.steps != stbs_pkg::STEP_MAX) begin
            res.steps = res.steps + 1'b1;
         end
         if (table_image[mid] == key) begin
            res.found = 1'b1;
            res.index = mid[stbs_pkg::IDX_W-1:0];
            done      = 1'b1;
         end else begin
            if (res.steps != stbs_pkg::STEP_MAX) begin
               res.steps = res.steps + 1'b1;
            end
            if (table_image[mid] < key) begin
               lo = mid + 1;
            end else begin
               hi = mid - 1;
            end
         end
      end
      return res;
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("%0t %s: expected %0h, got %0h", $time, what, want, got);
      end
   endtask

   task automatic drop_start();
      if (start_held) begin
         start      <= 1'b0;
         start_held = 1'b0;
      end
   endtask

   task automatic wait_drained();
      drop_start();
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic issue_request(input logic op, input logic [stbs_pkg::IDX_W-1:0] index,
                                input logic signed [stbs_pkg::VAL_W-1:0] value,
                                input logic signed [stbs_pkg::VAL_W-1:0] key,
                                input bit known, input search_result_type known_res);
      int pick;
      repeat (next_gap) @(posedge clock);
      start           <= 1'b1;
      req_opcode      <= op;
      req_entry_index <= index;
      req_entry_value <= value;
      req_search_key  <= key;
      start_held      = 1'b1;
      do @(posedge clock); while (busy !== 1'b0);
      requests_issued++;
      if (op == stbs_pkg::OP_SEARCH) begin
         searches_issued++;
         pending_results.push_back(known ? known_res : predict_search(key));
      end else begin
         table_image[index] = value;
         written[index]     = 1'b1;
      end
      pick = $urandom_range(0, 99);
      if (steady || pick < 60) begin
         next_gap = 0;
      end else if (pick < 90) begin
         next_gap = $urandom_range(1, 3);
      end else begin
         next_gap = $urandom_range(5, 40);
      end
      if (next_gap != 0) begin
         start      <= 1'b0;
         start_held = 1'b0;
      end
   endtask

   // write every unwritten entry on the probe path, each inside its own ascending band
   task automatic cover_path(input logic signed [stbs_pkg::VAL_W-1:0] key);
      longint level;
      int     lo;
      int     hi;
      int     mid;
      int     n;
      bit     done;
      done = 1'b0;
      n    = int'(table_length_cfg);
      if (n > DEPTH) begin
         n = DEPTH;
      end
      lo = 0;
      hi = n - 1;
      while (!done && lo <= hi) begin
         mid = (lo + hi) / 2;
         if (!written[mid]) begin
            level = longint'(mid) * 64'sd4194304 - 64'sd2147483648;
            if (mid == DEPTH - 1) begin
               level = level + 64'sd4194303;
            end else if (mid != 0) begin
               level = level + longint'($urandom_range(0, 4194303));
            end
            issue_request(stbs_pkg::OP_WRITE, stbs_pkg::IDX_W'(mid),
                          level[stbs_pkg::VAL_W-1:0], stbs_pkg::VAL_W'($urandom),
                          1'b0, '0);
         end
         if (table_image[mid] == key) begin
            done = 1'b1;
         end else if (table_image[mid] < key) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
         end
      end
   endtask

   task automatic csr_update(input logic [stbs_pkg::CSR_ADDR_W-1:0] addr,
                             input logic [stbs_pkg::CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (addr[stbs_pkg::CSR_ADDR_W-1:2] == stbs_pkg::REG_TABLE_LENGTH) begin
         table_length_cfg = data[stbs_pkg::LEN_W-1:0];
         length_updates++;
      end
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= LEN_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata !== stbs_pkg::CSR_DATA_W'(table_length_cfg)) begin
         note_mismatch("table_length readback", stbs_pkg::CSR_DATA_W'(table_length_cfg),
                       prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   always @(posedge clock) begin : result_check
      search_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_results.size() == 0) begin
            note_mismatch("result with no search pending", 32'd0, 32'd1);
         end else begin
            want = pending_results.pop_front();
            if (rsp_found === 1'b1) begin
               search_hits++;
            end
            if (rsp_found !== want.found) begin
               note_mismatch("found", 32'(want.found), 32'(rsp_found));
            end
            if (rsp_match_index !== want.index) begin
               note_mismatch("match_index", 32'(want.index), 32'(rsp_match_index));
            end
            if (rsp_step_count !== want.steps) begin
               note_mismatch("step_count", 32'(want.steps), 32'(rsp_step_count));
            end
         end
      end
   end

   initial begin
      directed_row_type                    rows [$];
      longint                              level;
      logic signed [stbs_pkg::VAL_W-1:0]   key;
      logic [stbs_pkg::CSR_DATA_W-1:0]     cfg_word;
      int                                  len;
      int                                  n;
      int                                  pick;
      int                                  slot;
      int                                  base_requests;

      reset           <= 1'b1;
      start           <= 1'b0;
      req_opcode      <= stbs_pkg::OP_WRITE;
      req_entry_index <= '0;
      req_entry_value <= '0;
      req_search_key  <= '0;
      psel            <= 1'b0;
      penable         <= 1'b0;
      pwrite          <= 1'b0;
      paddr           <= '0;
      pwdata          <= '0;
      table_length_cfg = stbs_pkg::LEN_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // no register at index 1: readback must still show the reset length
      csr_update(SPARE_ADDR, 32'd5);

      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h8000_0000, '0, 1'b0, '0});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h7FFF_FFFF, '0, 1'b0, '0});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h0000_0000, '0, 1'b0, '0});
      rows.push_back('{ROW_CSR,    LEN_ADDR, 32'd0,         '0, 1'b0, '0});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h0000_0000, '0, 1'b1, '{1'b0, 10'd0, 5'd0}});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h7FFF_FFFF, '0, 1'b1, '{1'b0, 10'd0, 5'd0}});
      rows.push_back('{ROW_CSR,    LEN_ADDR, 32'd1,         '0, 1'b0, '0});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h8000_0000, '0, 1'b1, '{1'b1, 10'd0, 5'd1}});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h7FFF_FFFF, '0, 1'b1, '{1'b0, 10'd0, 5'd2}});
      rows.push_back('{ROW_CSR,    LEN_ADDR, 32'd2,         '0, 1'b0, '0});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h7FFF_FFFF, '0, 1'b1, '{1'b0, 10'd0, 5'd4}});
      rows.push_back('{ROW_CSR,    LEN_ADDR, 32'hFFFF_FFFF, '0, 1'b0, '0});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h7FFF_FFFF, '0, 1'b0, '0});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h8000_0000, '0, 1'b0, '0});
      rows.push_back('{ROW_CSR,    SPARE_ADDR, 32'd3,       '0, 1'b0, '0});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h0000_0001, '0, 1'b0, '0});
      rows.push_back('{ROW_CSR,    LEN_ADDR, 32'd1024,      '0, 1'b0, '0});
      rows.push_back('{ROW_WRITE,  LEN_ADDR, 32'h8000_0000, 10'd511, 1'b0, '0});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h8000_0000, '0, 1'b1, '{1'b1, 10'd511, 5'd1}});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'h7FFF_FFFF, '0, 1'b0, '0});
      rows.push_back('{ROW_SEARCH, LEN_ADDR, 32'hFFFF_FFFF, '0, 1'b0, '0});

      foreach (rows[r]) begin
         case (rows[r].kind)
            ROW_CSR: begin
               wait_drained();
               csr_update(rows[r].addr, rows[r].value);
            end
            ROW_WRITE: begin
               issue_request(stbs_pkg::OP_WRITE, rows[r].index, rows[r].value,
                             stbs_pkg::VAL_W'($urandom), 1'b0, '0);
            end
            default: begin
               cover_path(rows[r].value);
               issue_request(stbs_pkg::OP_SEARCH, stbs_pkg::IDX_W'($urandom),
                             stbs_pkg::VAL_W'($urandom), rows[r].value,
                             rows[r].known, rows[r].result);
            end
         endcase
      end

      base_requests = requests_issued;
      while (requests_issued - base_requests < RANDOM_REQUESTS) begin
         pick = $urandom_range(0, 3);
         if (pick != 0) begin
            len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 48);
         end else begin
            case ($urandom_range(0, 3))
               0:       len = 1024;
               1:       len = 2047;
               2:       len = $urandom_range(49, 1023);
               default: len = $urandom_range(1025, 2047);
            endcase
         end
         n = (len > DEPTH) ? DEPTH : len;
         wait_drained();
         steady   = ($urandom_range(0, 3) == 0);
         cfg_word = $urandom;
         if ($urandom_range(0, 1) == 0) begin
            cfg_word = '0;
         end
         cfg_word[stbs_pkg::LEN_W-1:0] = stbs_pkg::LEN_W'(len);
         csr_update(LEN_ADDR, cfg_word);

         // rewrite a short table in ascending order, with duplicates and noise mixed in
         if (pick != 0 && n > 0) begin
            level = longint'($urandom_range(0, 32'hFFFF_FFFF - n * 1024)) - 64'sd2147483648;
            for (int i = 0; i < n; i++) begin
               if ($urandom_range(0, 7) == 0) begin
                  if ($urandom_range(0, 1) == 0) begin
                     issue_request(stbs_pkg::OP_WRITE, stbs_pkg::IDX_W'($urandom),
                                   stbs_pkg::VAL_W'($urandom),
                                   stbs_pkg::VAL_W'($urandom), 1'b0, '0);
                  end else begin
                     key = stbs_pkg::VAL_W'($urandom);
                     cover_path(key);
                     issue_request(stbs_pkg::OP_SEARCH, stbs_pkg::IDX_W'($urandom),
                                   stbs_pkg::VAL_W'($urandom), key, 1'b0, '0);
                  end
               end
               issue_request(stbs_pkg::OP_WRITE, stbs_pkg::IDX_W'(i),
                             level[stbs_pkg::VAL_W-1:0], stbs_pkg::VAL_W'($urandom),
                             1'b0, '0);
               if ($urandom_range(0, 7) != 0) begin
                  level = level + longint'($urandom_range(1, 1024));
               end
            end
         end

         if ($urandom_range(0, 3) == 0) begin
            wait_drained();
         end

         repeat ($urandom_range(6, 16)) begin
            pick = $urandom_range(0, 9);
            if (n > 0 && pick < 8) begin
               slot = $urandom_range(0, n - 1);
               key  = written[slot] ? table_image[slot] : stbs_pkg::VAL_W'($urandom);
               if (pick == 6) begin
                  key = key + 32'sd1;
               end else if (pick == 7) begin
                  key = key - 32'sd1;
               end
            end else begin
               key = stbs_pkg::VAL_W'($urandom);
            end
            cover_path(key);
            issue_request(stbs_pkg::OP_SEARCH, stbs_pkg::IDX_W'($urandom),
                          stbs_pkg::VAL_W'($urandom), key, 1'b0, '0);
         end
      end

      steady = 1'b0;
      wait_drained();
      $display("Ran %0d requests: %0d table writes, %0d searches, %0d of them hits",
               requests_issued, requests_issued - searches_issued, searches_issued,
               search_hits);
      $display("Covered %0d length settings incl. empty, over-range and unsorted tables",
               length_updates);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

@@ sim.f @@
src/stbs_pkg.sv
src/stbs_table_mem.sv
src/stbs_search_ctrl.sv
src/sorted_table_binary_search.sv
src/stbs_checker.sv
dv/tb_sorted_table_binary_search.sv
